// ----- hdl/rrae_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrae_pkg
// Shared types and codes for the reorder receiver ack engine: header and
// result beat layouts, slot store entry, packet and ack codes.
// ----------------------------------------------------------------------------
package rrae_pkg;

    localparam int SEQ_W    = 31;
    localparam int HANDLE_W = 16;
    localparam int LEN_W    = 12;
    localparam int REPS_W   = 5;

    localparam logic [REPS_W-1:0] REPS_RESET = 5'd3;

    // Packet type codes
    localparam logic FUNC_DATA = 1'b0;
    localparam logic FUNC_FIN  = 1'b1;

    // Acknowledgement type codes
    localparam logic ACK_PLAIN = 1'b0;
    localparam logic ACK_FIN   = 1'b1;

    typedef struct packed {
        logic                func;
        logic [SEQ_W-1:0]    seq_no;
        logic [HANDLE_W-1:0] payload_handle;
        logic [LEN_W-1:0]    pkt_len;
    } hdr_item_t;

    typedef struct packed {
        logic                ack_kind;
        logic [SEQ_W-1:0]    ack_no;
        logic                deliver;
        logic [HANDLE_W-1:0] deliver_handle;
        logic [LEN_W-1:0]    deliver_len;
        logic                dropped;
        logic                last;
    } ack_item_t;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [LEN_W-1:0]    len;
    } slot_entry_t;

endpackage

// ----- hdl/rrae_slot_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrae_slot_store
// Reorder slot store: one synchronous memory of buffer handle and length per
// slot with a registered read, plus a valid flag per slot that reset clears.
// ----------------------------------------------------------------------------
module rrae_slot_store #(
    parameter int WINDOW = 32,
    parameter int SLOT_W = 5
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  logic [SLOT_W-1:0]    wr_idx,
    input  rrae_pkg::slot_entry_t wr_data,
    input  logic                 clr_en,
    input  logic [SLOT_W-1:0]    clr_idx,
    input  logic                 rd_en,
    input  logic [SLOT_W-1:0]    rd_idx,
    output rrae_pkg::slot_entry_t rd_data,
    output logic [WINDOW-1:0]    valid
);

    rrae_pkg::slot_entry_t mem [WINDOW];
    rrae_pkg::slot_entry_t rd_data_reg;
    logic [WINDOW-1:0]     valid_reg;

    // Set a flag on store, drop it on release
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_idx] <= 1'b1;
            end
            if (clr_en)
            begin
                valid_reg[clr_idx] <= 1'b0;
            end
        end
    end

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_idx];
        end
    end

    assign rd_data = rd_data_reg;
    assign valid   = valid_reg;

endmodule

// ----- hdl/reorder_receiver_ack_engine_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reorder_receiver_ack_engine_unit
// Receive side of a reliable transport: acks headers, holds early packets in
// a reorder store and releases them in sequence order.
// ----------------------------------------------------------------------------
// One header is taken at a time. An item that yields a single ack beat has
// its beat loaded into the output register after the classify and emit
// states (S_EVAL, S_EMIT); a packet that goes into the reorder store also
// passes through the slot write state (S_STORE) between them. A fin has its
// finacks loaded one after another from the emit state. An in-order packet
// is released from S_DLV_IN and each further released payload from
// S_DLV_MEM: the drain walks the slot store, issuing the read of the next
// slot in the same cycle that the current beat is loaded, so the store's
// read latency is hidden. The next header is accepted once the block is back
// in idle after the last beat of an item is loaded; while the output register
// is stalled and full, a beat that waits to be loaded is held. Slot valid
// flags are cleared at reset, so no clearing pass is needed. The finack count
// register is written through its own port and is always ready.
// ----------------------------------------------------------------------------
module reorder_receiver_ack_engine_unit #(
    parameter int WINDOW = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          hdr_valid,
    output logic                          hdr_stall,
    input  rrae_pkg::hdr_item_t           hdr,
    output logic                          ack_valid,
    input  logic                          ack_stall,
    output rrae_pkg::ack_item_t           ack,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [rrae_pkg::REPS_W-1:0]   cfg_data
);

    localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_STORE,
        S_EMIT,
        S_DLV_IN,
        S_DLV_MEM
    } state_t;

    state_t                           state_reg, state_next;
    rrae_pkg::hdr_item_t              hdr_reg, hdr_next;
    logic [rrae_pkg::SEQ_W-1:0]       exp_reg, exp_next;
    logic [SLOT_W-1:0]                slot_reg, slot_next;
    logic                             closed_reg, closed_next;
    logic [rrae_pkg::REPS_W-1:0]      reps_reg, reps_next;
    logic [rrae_pkg::REPS_W-1:0]      cnt_reg, cnt_next;
    logic [SLOT_W-1:0]                dist_reg, dist_next;
    rrae_pkg::ack_item_t              res_reg, res_next;
    rrae_pkg::ack_item_t              out_reg, out_next;
    logic                             out_valid_reg, out_valid_next;

    logic                             st_wr_en;
    logic                             st_clr_en;
    logic                             st_rd_en;
    rrae_pkg::slot_entry_t            st_wr_data;
    rrae_pkg::slot_entry_t            st_rd_data;
    logic [WINDOW-1:0]                st_valid;

    logic                             exp_max;
    logic [SLOT_W-1:0]                slot_inc;
    logic                             more;
    logic [rrae_pkg::SEQ_W-1:0]       diff;
    logic [rrae_pkg::SEQ_W-1:0]       prev;
    logic [SLOT_W:0]                  store_sum;
    logic [SLOT_W-1:0]                store_idx;
    logic                             out_free;

    rrae_slot_store #(
        .WINDOW (WINDOW),
        .SLOT_W (SLOT_W)
    ) u_slot_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (st_wr_en),
        .wr_idx  (store_idx),
        .wr_data (st_wr_data),
        .clr_en  (st_clr_en),
        .clr_idx (slot_reg),
        .rd_en   (st_rd_en),
        .rd_idx  (slot_inc),
        .rd_data (st_rd_data),
        .valid   (st_valid)
    );

    // Slot of the next expected number; the count wraps to slot zero at 2^31
    assign exp_max  = &exp_reg;
    assign slot_inc = exp_max ? '0
                    : (slot_reg == SLOT_W'(WINDOW - 1)) ? '0
                    : slot_reg + 1'b1;
    // More to drain when the next slot holds an entry other than the one leaving
    assign more     = st_valid[slot_inc] && (slot_inc != slot_reg);

    // Header position against the expected number
    assign diff = hdr_reg.seq_no - exp_reg;
    assign prev = (exp_reg == '0) ? '0 : exp_reg - 1'b1;

    // Store slot: expected slot plus distance, folded once into the window
    assign store_sum = {1'b0, slot_reg} + {1'b0, dist_reg};
    assign store_idx = (store_sum >= (SLOT_W+1)'(WINDOW))
                     ? SLOT_W'(store_sum - (SLOT_W+1)'(WINDOW))
                     : store_sum[SLOT_W-1:0];

    assign st_wr_data.handle = hdr_reg.payload_handle;
    assign st_wr_data.len    = hdr_reg.pkt_len;

    assign out_free = !out_valid_reg || !ack_stall;

    // Next-state and datapath
    always_comb
    begin
        state_next     = state_reg;
        hdr_next       = hdr_reg;
        exp_next       = exp_reg;
        slot_next      = slot_reg;
        closed_next    = closed_reg;
        reps_next      = reps_reg;
        cnt_next       = cnt_reg;
        dist_next      = dist_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && ack_stall;
        st_wr_en       = 1'b0;
        st_clr_en      = 1'b0;
        st_rd_en       = 1'b0;

        // Take a register write
        if (cfg_valid)
        begin
            reps_next = cfg_data;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (hdr_valid)
                begin
                    hdr_next   = hdr;
                    state_next = S_EVAL;
                end
            end

            S_EVAL:
            begin
                res_next          = '0;
                res_next.ack_kind = rrae_pkg::ACK_PLAIN;
                cnt_next          = rrae_pkg::REPS_W'(1);
                if (closed_reg)
                begin
                    res_next.ack_kind = rrae_pkg::ACK_FIN;
                    res_next.ack_no   = exp_reg;
                    state_next        = S_EMIT;
                end
                else if (hdr_reg.func == rrae_pkg::FUNC_FIN)
                begin
                    res_next.ack_kind = rrae_pkg::ACK_FIN;
                    res_next.ack_no   = exp_reg;
                    cnt_next          = (reps_reg == '0) ? rrae_pkg::REPS_W'(1) : reps_reg;
                    closed_next       = 1'b1;
                    state_next        = S_EMIT;
                end
                else if (hdr_reg.seq_no < exp_reg)
                begin
                    res_next.ack_no = hdr_reg.seq_no;
                    state_next      = S_EMIT;
                end
                else if (hdr_reg.seq_no == exp_reg)
                begin
                    state_next = S_DLV_IN;
                end
                else
                begin
                    res_next.ack_no = prev;
                    if (diff >= rrae_pkg::SEQ_W'(WINDOW))
                    begin
                        res_next.dropped = 1'b1;
                        state_next       = S_EMIT;
                    end
                    else
                    begin
                        dist_next  = diff[SLOT_W-1:0];
                        state_next = S_STORE;
                    end
                end
            end

            // Keep the first copy of an early packet
            S_STORE:
            begin
                st_wr_en   = !st_valid[store_idx];
                state_next = S_EMIT;
            end

            // Send the prepared beat, repeated for finacks
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_next       = res_reg;
                    out_next.last  = (cnt_reg == rrae_pkg::REPS_W'(1));
                    out_valid_next = 1'b1;
                    cnt_next       = cnt_reg - 1'b1;
                    if (cnt_reg == rrae_pkg::REPS_W'(1))
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            // Release the arriving packet, then walk the store
            S_DLV_IN,
            S_DLV_MEM:
            begin
                if (out_free)
                begin
                    out_next          = '0;
                    out_next.ack_kind = rrae_pkg::ACK_PLAIN;
                    out_next.ack_no   = exp_reg;
                    out_next.deliver  = 1'b1;
                    if (state_reg == S_DLV_IN)
                    begin
                        out_next.deliver_handle = hdr_reg.payload_handle;
                        out_next.deliver_len    = hdr_reg.pkt_len;
                    end
                    else
                    begin
                        out_next.deliver_handle = st_rd_data.handle;
                        out_next.deliver_len    = st_rd_data.len;
                    end
                    out_next.last  = !more;
                    out_valid_next = 1'b1;
                    st_clr_en      = 1'b1;
                    st_rd_en       = more;
                    exp_next       = exp_reg + 1'b1;
                    slot_next      = slot_inc;
                    state_next     = more ? S_DLV_MEM : S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            exp_reg       <= '0;
            slot_reg      <= '0;
            closed_reg    <= 1'b0;
            reps_reg      <= rrae_pkg::REPS_RESET;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            exp_reg       <= exp_next;
            slot_reg      <= slot_next;
            closed_reg    <= closed_next;
            reps_reg      <= reps_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        hdr_reg  <= hdr_next;
        dist_reg <= dist_next;
        res_reg  <= res_next;
        out_reg  <= out_next;
    end

    assign hdr_stall = (state_reg != S_IDLE);
    assign ack_valid = out_valid_reg;
    assign ack       = out_reg;
    assign cfg_ready = 1'b1;

    // A beat without a release carries no buffer tag
    a_no_dlv_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (ack_valid && !ack.deliver) |-> (ack.deliver_handle == '0 && ack.deliver_len == '0))
        else $error("non-delivery beat carries payload fields");

    // A drop is a single plain ack without a release
    a_drop_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (ack_valid && ack.dropped) |->
            (ack.ack_kind == rrae_pkg::ACK_PLAIN && !ack.deliver && ack.last))
        else $error("dropped beat has wrong shape");

    // Once closed the block stays closed
    a_closed_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        closed_reg |=> closed_reg)
        else $error("closed flag cleared");

    // A finack only appears after close
    a_finack_closed: assert property (@(posedge clk) disable iff (!rst_n)
        (ack_valid && ack.ack_kind == rrae_pkg::ACK_FIN) |-> closed_reg)
        else $error("finack while open");

endmodule
